>>> design/timestamp_ordered_queue_macros.svh
// Assertion macros shared by the timestamp ordered queue modules.
`ifndef TIMESTAMP_ORDERED_QUEUE_MACROS_SVH
`define TIMESTAMP_ORDERED_QUEUE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TOQ_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define TOQ_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

>>> design/toq_pkg.sv
// Package with types and constants of the timestamp ordered queue.
`timescale 1ns / 1ps
package toq_pkg;
    localparam int DEPTH = 16;
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        K_PUSH = 3'd0, K_POP = 3'd1, K_PEEK = 3'd2, K_FIND_TS = 3'd3,
        K_FIND_SEQ = 3'd4, K_FIND_FRAME = 3'd5, K_EXPIRE = 3'd6, K_CLEAR = 3'd7
    } kind_t;

    localparam logic CFG_KEEP_SORTED = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE, S_PUSH, S_SCAN, S_SORT, S_RANGE, S_DONE
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic latch;      // capture the command beat
        logic push_wr;    // write the tail slot
        logic pop_head;   // drop the head entry
        logic clear;      // empty the queue
        logic scan_start; // reset walk index for find or expire
        logic scan_step;  // advance walk
        logic sort_start;
        logic sort_step;
        logic range_start;
        logic range_step;
        logic emit;       // drive result strobe
    } cmd_t;

    // Status back to controller.
    typedef struct packed {
        logic [2:0] kind;
        logic full;
        logic empty;
        logic scan_done;  // walk finished or match found
        logic sort_done;
        logic range_done;
        logic sorted_mode;
    } stat_t;
endpackage

>>> design/toq_ctrl.sv
// Controller state machine of the timestamp ordered queue.
`timescale 1ns / 1ps
`include "timestamp_ordered_queue_macros.svh"
module toq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  toq_pkg::stat_t stat,
    output toq_pkg::cmd_t  cmd
);
    import toq_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_PUSH;
            S_PUSH:
            begin
                unique case (kind_t'(stat.kind))
                    K_PUSH:
                        if (stat.full) state_next = S_DONE;
                        else if (stat.sorted_mode) state_next = S_SORT;
                        else state_next = S_RANGE;
                    K_POP:   state_next = stat.empty ? S_DONE : S_RANGE;
                    K_PEEK, K_CLEAR: state_next = S_DONE;
                    default: state_next = S_SCAN;
                endcase
            end
            S_SCAN:
                if (stat.scan_done)
                    state_next = (kind_t'(stat.kind) == K_EXPIRE) ? S_RANGE : S_DONE;
            S_SORT:  if (stat.sort_done) state_next = S_RANGE;
            S_RANGE: if (stat.range_done) state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE: cmd.latch = start;
            S_PUSH:
            begin
                unique case (kind_t'(stat.kind))
                    K_PUSH:
                    begin
                        cmd.push_wr = !stat.full;
                        cmd.sort_start = !stat.full && stat.sorted_mode;
                        cmd.range_start = !stat.full && !stat.sorted_mode;
                    end
                    K_POP:
                    begin
                        cmd.pop_head = !stat.empty;
                        cmd.range_start = !stat.empty;
                    end
                    K_CLEAR: cmd.clear = 1'b1;
                    K_PEEK:  ;
                    default: cmd.scan_start = 1'b1;
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                // Only expire goes on to a range walk; a find keeps the held range.
                cmd.range_start = stat.scan_done && (kind_t'(stat.kind) == K_EXPIRE);
            end
            S_SORT:
            begin
                cmd.sort_step = 1'b1;
                cmd.range_start = stat.sort_done;
            end
            S_RANGE: cmd.range_step = 1'b1;
            S_DONE: cmd.emit = 1'b1;
            default: ;
        endcase
    end

    `TOQ_ASSERT_IMP(a_latch_idle, clk, rst_n, cmd.latch, state_reg == S_IDLE)
    `TOQ_ASSERT_NEXT(a_done_idle, clk, rst_n, state_reg == S_DONE, state_reg == S_IDLE)
    `TOQ_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
endmodule

>>> design/toq_datapath.sv
// Datapath of the timestamp ordered queue: slot store, walker, sorter, range.
`timescale 1ns / 1ps
`include "timestamp_ordered_queue_macros.svh"
module toq_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  toq_pkg::cmd_t  cmd,
    output toq_pkg::stat_t stat,
    input  logic           cfg_valid,
    input  logic           cfg_index,
    input  logic [4:0]     cfg_data,
    input  logic [2:0]     kind,
    input  logic [63:0]    stamp,
    input  logic [31:0]    seq_key,
    input  logic [31:0]    frame_key,
    input  logic [63:0]    match_tolerance,
    input  logic [63:0]    now_time,
    input  logic [63:0]    age_limit,
    output logic           done,
    output logic           ok,
    output logic [63:0]    out_stamp,
    output logic [31:0]    out_seq,
    output logic [31:0]    out_frame,
    output logic [63:0]    out_arrival,
    output logic [4:0]     removed,
    output logic [4:0]     fill,
    output logic [63:0]    oldest,
    output logic [63:0]    newest
);
    import toq_pkg::*;

    // Slot store, held in flip-flops: the sorter touches two neighbours a cycle.
    logic [63:0] st_mem [DEPTH];
    logic [31:0] sq_mem [DEPTH];
    logic [31:0] fr_mem [DEPTH];
    logic [63:0] ar_mem [DEPTH];

    logic [IW-1:0] head_reg, tail_reg;
    logic [CW-1:0] held_reg, cap_reg;
    logic          sorted_reg;
    logic [63:0]   min_reg, max_reg;
    logic [2:0]    kind_reg;
    logic [63:0]   stamp_reg, tol_reg, aux_reg, arr_reg;
    logic [31:0]   seq_reg, frame_reg;
    logic [CW-1:0] idx_reg, pass_reg, rem_reg;
    logic          found_reg, walk_end_reg;
    logic          ok_reg;
    logic          done_reg;
    logic [63:0]   os_reg, oa_reg;
    logic [31:0]   oq_reg, of_reg;

    // Ring index wrapping at the capacity in use.
    function automatic logic [IW-1:0] ring(input logic [IW-1:0] base,
                                           input logic [CW-1:0] off,
                                           input logic [CW-1:0] cap);
        logic [CW:0] s;
        s = {{(CW + 1 - IW){1'b0}}, base} + {1'b0, off};
        if (s >= {1'b0, cap}) s = s - {1'b0, cap};
        return s[IW-1:0];
    endfunction

    logic [CW-1:0] cap_w;
    always_comb
    begin
        if (cfg_data == '0) cap_w = CW'(1);
        else if (cfg_data > 5'(DEPTH)) cap_w = CW'(DEPTH);
        else cap_w = CW'(cfg_data);
    end

    // Walk over held entries.
    logic [IW-1:0] ws, wn;
    logic [63:0]   diff, thr;
    logic          hit;
    logic          swap;
    assign ws = ring(head_reg, idx_reg, cap_reg);
    assign wn = ring(head_reg, idx_reg + CW'(1), cap_reg);
    assign thr = aux_reg;
    always_comb
    begin
        diff = (st_mem[ws] > stamp_reg) ? st_mem[ws] - stamp_reg : stamp_reg - st_mem[ws];
        unique case (kind_t'(kind_reg))
            K_FIND_TS:    hit = diff <= tol_reg;
            K_FIND_SEQ:   hit = sq_mem[ws] == seq_reg;
            K_FIND_FRAME: hit = fr_mem[ws] == frame_reg;
            default:      hit = st_mem[ws] < thr;
        endcase
        if (st_mem[ws] != st_mem[wn]) swap = st_mem[ws] > st_mem[wn];
        else swap = sq_mem[ws] > sq_mem[wn];
    end

    logic scan_done, sort_done, range_done;
    assign scan_done  = (idx_reg >= held_reg) || walk_end_reg;
    assign sort_done  = (held_reg < CW'(2)) || (pass_reg + CW'(1) >= held_reg);
    assign range_done = (idx_reg + CW'(1) >= held_reg) || (held_reg == '0);

    assign stat.kind = kind_reg;
    assign stat.full = held_reg >= cap_reg;
    assign stat.empty = held_reg == '0;
    assign stat.scan_done = scan_done;
    assign stat.sort_done = sort_done;
    assign stat.range_done = range_done;
    assign stat.sorted_mode = sorted_reg;

    // Control state: pointers, fill, configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0; tail_reg <= '0; held_reg <= '0;
            cap_reg <= CW'(DEPTH); sorted_reg <= 1'b0;
            min_reg <= '0; max_reg <= '0; done_reg <= 1'b0;
            idx_reg <= '0; pass_reg <= '0; rem_reg <= '0;
            found_reg <= 1'b0; walk_end_reg <= 1'b0; ok_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_KEEP_SORTED) sorted_reg <= cfg_data[0];
                else
                begin
                    cap_reg <= cap_w; head_reg <= '0; tail_reg <= '0;
                    held_reg <= '0; min_reg <= '0; max_reg <= '0;
                end
            end
            if (cmd.latch)
            begin
                ok_reg <= 1'b0; found_reg <= 1'b0; rem_reg <= '0;
                walk_end_reg <= 1'b0;
            end
            if (cmd.push_wr)
            begin
                tail_reg <= ring(tail_reg, CW'(1), cap_reg);
                held_reg <= held_reg + CW'(1);
                ok_reg <= 1'b1;
            end
            if (cmd.pop_head)
            begin
                head_reg <= ring(head_reg, CW'(1), cap_reg);
                held_reg <= held_reg - CW'(1);
                ok_reg <= 1'b1;
            end
            if (kind_t'(kind_reg) == K_PEEK && cmd.emit && held_reg != '0) ok_reg <= 1'b1;
            if (cmd.clear)
            begin
                head_reg <= '0; tail_reg <= '0; held_reg <= '0;
                min_reg <= '0; max_reg <= '0;
            end
            if (cmd.scan_start) idx_reg <= '0;
            if (cmd.scan_step && !scan_done)
            begin
                if (kind_t'(kind_reg) == K_EXPIRE)
                begin
                    if (hit)
                    begin
                        head_reg <= ring(head_reg, CW'(1), cap_reg);
                        held_reg <= held_reg - CW'(1);
                        rem_reg <= rem_reg + CW'(1);
                    end
                    else walk_end_reg <= 1'b1;
                end
                else if (hit)
                begin
                    found_reg <= 1'b1; ok_reg <= 1'b1; walk_end_reg <= 1'b1;
                end
                else idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.sort_start)
            begin
                pass_reg <= '0; idx_reg <= '0;
            end
            if (cmd.sort_step && !sort_done)
            begin
                if (idx_reg + CW'(2) >= held_reg - pass_reg)
                begin
                    idx_reg <= '0; pass_reg <= pass_reg + CW'(1);
                end
                else idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.range_start)
            begin
                idx_reg <= '0;
                min_reg <= '1; max_reg <= '0;
            end
            if (cmd.range_step && held_reg != '0)
            begin
                if (st_mem[ws] < min_reg) min_reg <= st_mem[ws];
                if (st_mem[ws] > max_reg) max_reg <= st_mem[ws];
                idx_reg <= idx_reg + CW'(1);
            end
        end
    end

    // Command fields and the returned entry.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= kind; stamp_reg <= stamp; seq_reg <= seq_key;
            frame_reg <= frame_key; tol_reg <= match_tolerance;
            aux_reg <= now_time - age_limit;
            arr_reg <= now_time;
            os_reg <= '0; oq_reg <= '0; of_reg <= '0; oa_reg <= '0;
        end
        if (cmd.push_wr)
        begin
            st_mem[tail_reg] <= stamp_reg; sq_mem[tail_reg] <= seq_reg;
            fr_mem[tail_reg] <= frame_reg; ar_mem[tail_reg] <= arr_reg;
        end
        if ((cmd.pop_head || (cmd.emit && kind_t'(kind_reg) == K_PEEK && held_reg != '0)))
        begin
            os_reg <= st_mem[head_reg]; oq_reg <= sq_mem[head_reg];
            of_reg <= fr_mem[head_reg]; oa_reg <= ar_mem[head_reg];
        end
        if (cmd.scan_step && !scan_done && hit && kind_t'(kind_reg) != K_EXPIRE)
        begin
            os_reg <= st_mem[ws]; oq_reg <= sq_mem[ws];
            of_reg <= fr_mem[ws]; oa_reg <= ar_mem[ws];
        end
        if (cmd.sort_step && !sort_done && swap)
        begin
            st_mem[ws] <= st_mem[wn]; st_mem[wn] <= st_mem[ws];
            sq_mem[ws] <= sq_mem[wn]; sq_mem[wn] <= sq_mem[ws];
            fr_mem[ws] <= fr_mem[wn]; fr_mem[wn] <= fr_mem[ws];
            ar_mem[ws] <= ar_mem[wn]; ar_mem[wn] <= ar_mem[ws];
        end
    end

    // Result beat; peek results are registered together with the strobe, so they appear with done.
    always_comb
    begin
        done = done_reg;
        ok = ok_reg;
        out_stamp = os_reg; out_seq = oq_reg; out_frame = of_reg; out_arrival = oa_reg;
        removed = 5'(rem_reg);
        fill = 5'(held_reg);
        oldest = (held_reg != '0) ? min_reg : '0;
        newest = (held_reg != '0) ? max_reg : '0;
    end

    `TOQ_ASSERT_IMP(a_held_cap, clk, rst_n, 1'b1, held_reg <= cap_reg)
    `TOQ_ASSERT_IMP(a_found_ok, clk, rst_n, found_reg, ok_reg)
    `TOQ_ASSERT_NEXT(a_push_grow, clk, rst_n, cmd.push_wr, held_reg == $past(held_reg) + CW'(1))
endmodule

>>> design/timestamp_ordered_queue.sv
// Top level of the timestamp ordered queue.
`timescale 1ns / 1ps
// Timestamp ordered ring queue of up to sixteen frame timestamp entries.
// Commands are issued on kind and the key fields with start; a command beat
// is taken when start is high and busy is low. Busy stays high until the
// result beat, which appears on the result ports for one cycle with done.
// The receiver cannot stall: each result must be taken in its cycle.
// Configuration beats use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high; writes must go in only while busy is low, which the block does not enforce.
// Peek, clear, a refused push and a failed pop go straight to the done state.
// A pop or plain push then walks the held entries to update oldest and
// newest; a sorted push first bubble sorts the entries by stamp, then
// walks them. A find walks entries until a match or the end; an expire
// drops expired entries from the head until one is kept, then walks
// the rest. Busy falls when done rises, so one command is in flight.
// Reset empties the queue, clears sorted mode and sets capacity to sixteen;
// slot contents are left unwritten.
module timestamp_ordered_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic [2:0]  kind,
    input  logic [63:0] stamp,
    input  logic [31:0] seq_key,
    input  logic [31:0] frame_key,
    input  logic [63:0] match_tolerance,
    input  logic [63:0] now_time,
    input  logic [63:0] age_limit,
    output logic        done,
    output logic        ok,
    output logic [63:0] out_stamp,
    output logic [31:0] out_seq,
    output logic [31:0] out_frame,
    output logic [63:0] out_arrival,
    output logic [4:0]  removed,
    output logic [4:0]  fill,
    output logic [63:0] oldest,
    output logic [63:0] newest
);
    import toq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    // Controller.
    toq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
    );

    // Datapath.
    toq_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .kind(kind), .stamp(stamp), .seq_key(seq_key), .frame_key(frame_key),
        .match_tolerance(match_tolerance), .now_time(now_time), .age_limit(age_limit),
        .done(done), .ok(ok), .out_stamp(out_stamp), .out_seq(out_seq),
        .out_frame(out_frame), .out_arrival(out_arrival), .removed(removed),
        .fill(fill), .oldest(oldest), .newest(newest)
    );
endmodule
